### sv/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

	// default number of group entries between front and back
	localparam int QueueDepth = 2;

	localparam logic [6:0] PadChar = 7'd61;

	// one raw byte transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// one encoded character transaction
	typedef struct packed {
		logic [6:0] out_char;
		logic       end_of_text;
	} out_item_t;

	// one 24-bit group handed from front to back
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  pad_count;
		logic        last;
	} group_t;

	// sextet to ascii: A-Z a-z 0-9 + /
	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] c;
		c = 7'd0;
		if (v < 6'd26) begin
			c = 7'd65 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'd71 + {1'b0, v};
		end else if (v < 6'd62) begin
			c = {1'b0, v} - 7'd4;
		end else if (v == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

### sv/base64_stream_encoder.sv
`timescale 1ns / 1ps

// Streaming base64 encoder (A-Z a-z 0-9 + /, '=' padding). Raw bytes enter one per
// transaction, final_byte marking the end of a message; encoded characters leave one per
// transaction, end_of_text marking the last. A front stage collects bytes into 24-bit
// groups and accepts a byte every cycle while the group queue (QUEUE_DEPTH entries) has
// room; a back stage turns each group into four characters through a registered output,
// one character per cycle while char_ready is high and groups are queued. The character
// port sets the sustained rate: four characters per group, also for a one- or two-byte
// tail. The first character of a group passes through the group queue, the back stage's
// working group register and the output register before it is valid.
// No reset sweep: the block is ready as soon as reset is released.
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = b64e_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  b64e_pkg::in_item_t  byte_data,
	output logic                char_valid,
	input  logic                char_ready,
	output b64e_pkg::out_item_t char_data
);

	logic             push;
	b64e_pkg::group_t push_group;
	logic             queue_full;
	logic             pop;
	logic             queue_not_empty;
	b64e_pkg::group_t pop_group;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.queue_full (queue_full),
		.push       (push),
		.push_group (push_group)
	);

	b64e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (queue_not_empty),
		.pop_group  (pop_group)
	);

	b64e_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.queue_not_empty (queue_not_empty),
		.queue_group     (pop_group),
		.pop             (pop),
		.char_valid      (char_valid),
		.char_ready      (char_ready),
		.char_data       (char_data)
	);

endmodule

### sv/b64e_front.sv
`timescale 1ns / 1ps

module b64e_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  b64e_pkg::in_item_t byte_data,
	input  logic               queue_full,
	output logic               push,
	output b64e_pkg::group_t   push_group
);

	logic [1:0]  pending_count_q;
	logic [15:0] pending_bytes_q;
	logic        accept;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;

	// classify the byte against the pending group
	always_comb begin
		push       = 1'b0;
		push_group = '0;
		unique case (pending_count_q)
			2'd1: begin
				push_group.word      = {pending_bytes_q[15:8], byte_data.data_byte, 8'd0};
				push_group.pad_count = 2'd1;
				push_group.last      = 1'b1;
				push                 = accept && byte_data.final_byte;
			end
			2'd2: begin
				push_group.word      = {pending_bytes_q, byte_data.data_byte};
				push_group.pad_count = 2'd0;
				push_group.last      = byte_data.final_byte;
				push                 = accept;
			end
			default: begin
				push_group.word      = {byte_data.data_byte, 16'd0};
				push_group.pad_count = 2'd2;
				push_group.last      = 1'b1;
				push                 = accept && byte_data.final_byte;
			end
		endcase
	end

	// pending byte state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_count_q <= 2'd0;
			pending_bytes_q <= 16'd0;
		end else if (accept) begin
			if (push) begin
				pending_count_q <= 2'd0;
				pending_bytes_q <= 16'd0;
			end else if (pending_count_q == 2'd1) begin
				pending_count_q <= 2'd2;
				pending_bytes_q <= {pending_bytes_q[15:8], byte_data.data_byte};
			end else begin
				pending_count_q <= 2'd1;
				pending_bytes_q <= {byte_data.data_byte, 8'd0};
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_count_q != 2'd3) else $error("pending count reached three");
	a_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept) else $error("group pushed without a byte transaction");
`endif

endmodule

### sv/b64e_fifo.sv
`timescale 1ns / 1ps

module b64e_fifo #(
	parameter int DEPTH = b64e_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64e_pkg::group_t push_group,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output b64e_pkg::group_t pop_group
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	b64e_pkg::group_t mem [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full      = (count_q == CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_group = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_group;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
`endif

endmodule

### sv/b64e_back.sv
`timescale 1ns / 1ps

module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                queue_not_empty,
	input  b64e_pkg::group_t    queue_group,
	output logic                pop,
	output logic                char_valid,
	input  logic                char_ready,
	output b64e_pkg::out_item_t char_data
);

	logic             busy_q;
	logic [1:0]       idx_q;
	b64e_pkg::group_t group_q;
	logic             out_valid_q;
	logic             out_load;
	logic             group_done;
	logic [5:0]       sextet;
	logic             is_pad;
	logic [6:0]       next_char;

	assign out_load   = busy_q && (!out_valid_q || char_ready);
	assign group_done = out_load && (idx_q == 2'd3);
	assign pop        = queue_not_empty && (!busy_q || group_done);
	assign char_valid = out_valid_q;

	// pick the sextet for the current position, most significant first
	always_comb begin
		unique case (idx_q)
			2'd0: sextet = group_q.word[23:18];
			2'd1: sextet = group_q.word[17:12];
			2'd2: sextet = group_q.word[11:6];
			2'd3: sextet = group_q.word[5:0];
		endcase
	end

	assign is_pad    = ({1'b0, idx_q} + {1'b0, group_q.pad_count}) >= 3'd4;
	assign next_char = is_pad ? b64e_pkg::PadChar : b64e_pkg::sextet_char(sextet);

	// working group and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (group_done) begin
				busy_q <= 1'b0;
				idx_q  <= 2'd0;
			end else if (out_load) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			group_q <= queue_group;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (char_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_data.out_char    <= next_char;
			char_data.end_of_text <= group_q.last && (idx_q == 2'd3);
		end
	end

`ifndef NO_ASSERTIONS
	a_pad_tail: assert property (@(posedge clk) disable iff (!arst_n)
		group_done && (group_q.pad_count != 2'd0) |=>
			char_data.end_of_text && (char_data.out_char == b64e_pkg::PadChar))
		else $error("padded group did not end with marked pad");
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop && busy_q |-> group_done) else $error("group replaced before finished");
`endif

endmodule
